// ===== rtl/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge, idle while reset is applied
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// condition that must never be seen on a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
	`ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

// ===== rtl/elv_pkg.sv =====
`timescale 1ns / 1ps

package elv_pkg;

	// default number of floors served
	localparam int FLOORS_DEF = 4;

	typedef logic [1:0] mode_t;
	typedef logic [1:0] motor_t;

	// controller modes
	localparam mode_t MODE_INIT = 2'd0;
	localparam mode_t MODE_WAIT = 2'd1;
	localparam mode_t MODE_UP   = 2'd2;
	localparam mode_t MODE_DOWN = 2'd3;

	// motor commands
	localparam motor_t MOTOR_STOP = 2'd0;
	localparam motor_t MOTOR_UP   = 2'd1;
	localparam motor_t MOTOR_DOWN = 2'd2;

	// travel direction memory
	localparam logic DIR_UP   = 1'b0;
	localparam logic DIR_DOWN = 1'b1;

	// request scan results handed from the request logic to the controller
	typedef struct packed {
		logic sensed;
		logic hit;
		logic at_top;
		logic at_bottom;
		logic ahead_up;
		logic ahead_down;
		logic at_or_above;
		logic any_pending;
	} reqs_stat_t;

endpackage

// ===== rtl/elv_req_if.sv =====
`timescale 1ns / 1ps

interface elv_req_if #(
	parameter int FLOORS = elv_pkg::FLOORS_DEF
);
	localparam int FLOOR_W = $clog2(FLOORS);

	logic               valid;
	logic               ready;
	logic               sensor_valid;
	logic [FLOOR_W-1:0] sensor_floor;
	logic [FLOORS-1:0]  up_presses;
	logic [FLOORS-1:0]  down_presses;
	logic [FLOORS-1:0]  cab_presses;
	logic               timer_expired;

	modport source (
		output valid, sensor_valid, sensor_floor, up_presses, down_presses, cab_presses,
		output timer_expired,
		input  ready
	);

	modport sink (
		input  valid, sensor_valid, sensor_floor, up_presses, down_presses, cab_presses,
		input  timer_expired,
		output ready
	);

endinterface

// ===== rtl/elv_rsp_if.sv =====
`timescale 1ns / 1ps

interface elv_rsp_if #(
	parameter int FLOORS = elv_pkg::FLOORS_DEF
);
	localparam int FLOOR_W = $clog2(FLOORS);

	logic               valid;
	logic               ready;
	logic [1:0]         motor_drive;
	logic               door_is_open;
	logic [FLOOR_W-1:0] floor_shown;
	logic [FLOORS-1:0]  up_lamps;
	logic [FLOORS-1:0]  down_lamps;
	logic [FLOORS-1:0]  cab_lamps;
	logic               timer_start;
	logic [1:0]         mode_now;

	modport source (
		output valid, motor_drive, door_is_open, floor_shown, up_lamps, down_lamps,
		output cab_lamps, timer_start, mode_now,
		input  ready
	);

	modport sink (
		input  valid, motor_drive, door_is_open, floor_shown, up_lamps, down_lamps,
		input  cab_lamps, timer_start, mode_now,
		output ready
	);

endinterface

// ===== rtl/elv_reqs.sv =====
`timescale 1ns / 1ps

module elv_reqs #(
	parameter int FLOORS = elv_pkg::FLOORS_DEF
) (
	input  logic                       hold,
	input  logic                       sensor_valid,
	input  logic [$clog2(FLOORS)-1:0]  sensor_floor,
	input  logic [FLOORS-1:0]          up_presses,
	input  logic [FLOORS-1:0]          down_presses,
	input  logic [FLOORS-1:0]          cab_presses,
	input  logic [$clog2(FLOORS)-1:0]  floor_q,
	input  logic                       door_q,
	input  logic [FLOORS-1:0]          up_q,
	input  logic [FLOORS-1:0]          dn_q,
	input  logic [FLOORS-1:0]          cab_q,
	output logic [$clog2(FLOORS)-1:0]  floor_d,
	output logic [FLOORS-1:0]          up_d,
	output logic [FLOORS-1:0]          dn_d,
	output logic [FLOORS-1:0]          cab_d,
	output elv_pkg::reqs_stat_t        stat
);
	import elv_pkg::*;

	localparam int FLOOR_W = $clog2(FLOORS);
	localparam logic [FLOORS-1:0] TOP_BIT = {1'b1, {(FLOORS-1){1'b0}}};
	localparam logic [FLOORS-1:0] BOT_BIT = FLOORS'(1);

	logic              sensed;
	logic [FLOORS-1:0] sel;
	logic [FLOORS-1:0] above;
	logic [FLOORS-1:0] below;
	logic [FLOORS-1:0] clr;
	logic [FLOORS-1:0] all_d;

	// a floor index past the top counts as no floor
	assign sensed  = sensor_valid && (int'(sensor_floor) < FLOORS);
	assign floor_d = sensed ? sensor_floor : floor_q;

	// per-floor position masks against the sensed and the updated floor
	always_comb begin
		for (int i = 0; i < FLOORS; i++) begin
			sel[i]   = sensed && (sensor_floor == FLOOR_W'(i));
			above[i] = FLOOR_W'(i) > floor_d;
			below[i] = FLOOR_W'(i) < floor_d;
		end
	end

	// latch presses unless hold is set, then drop everything at an open-door floor
	assign clr = (sensed && door_q) ? sel : '0;

	always_comb begin
		if (hold) begin
			up_d  = up_q;
			dn_d  = dn_q;
			cab_d = cab_q;
		end else begin
			up_d  = (up_q | (up_presses & ~TOP_BIT)) & ~clr;
			dn_d  = (dn_q | (down_presses & ~BOT_BIT)) & ~clr;
			cab_d = (cab_q | cab_presses) & ~clr;
		end
	end

	// scans used for stopping and direction choice
	assign all_d = up_d | dn_d | cab_d;

	always_comb begin
		stat.sensed      = sensed;
		stat.hit         = |(all_d & sel);
		stat.at_top      = sensed && (sensor_floor == FLOOR_W'(FLOORS - 1));
		stat.at_bottom   = sensed && (sensor_floor == '0);
		stat.ahead_up    = |((up_d | cab_d) & above);
		stat.ahead_down  = |((dn_d | cab_d) & below);
		stat.at_or_above = |(all_d & ~below);
		stat.any_pending = |all_d;
	end

endmodule

// ===== rtl/elv_ctrl.sv =====
`timescale 1ns / 1ps

module elv_ctrl (
	input  elv_pkg::mode_t      mode_q,
	input  logic                dir_q,
	input  logic                door_q,
	input  elv_pkg::motor_t     motor_q,
	input  logic                expired,
	input  elv_pkg::reqs_stat_t stat,
	output elv_pkg::mode_t      mode_d,
	output logic                dir_d,
	output logic                door_d,
	output elv_pkg::motor_t     motor_d,
	output logic                pulse_d
);
	import elv_pkg::*;

	mode_t mode_mid;

	// mode, door and motor update for one tick
	always_comb begin
		mode_d   = mode_q;
		dir_d    = dir_q;
		door_d   = door_q;
		motor_d  = motor_q;
		pulse_d  = 1'b0;
		mode_mid = mode_q;
		if (mode_q == MODE_INIT) begin
			// climb until the first floor sensor is seen
			dir_d = DIR_UP;
			if (stat.sensed) begin
				door_d  = 1'b1;
				motor_d = MOTOR_STOP;
				pulse_d = 1'b1;
				mode_d  = MODE_WAIT;
			end else begin
				motor_d = MOTOR_UP;
			end
		end else begin
			// stop at a floor that still has a request
			if (stat.hit) begin
				mode_mid = MODE_WAIT;
				if (mode_q != MODE_WAIT) begin
					door_d  = 1'b1;
					motor_d = MOTOR_STOP;
					pulse_d = 1'b1;
				end
			end
			mode_d = mode_mid;
			case (mode_mid)
				MODE_UP: begin
					door_d  = 1'b0;
					dir_d   = DIR_UP;
					motor_d = MOTOR_UP;
					if (stat.at_top) begin
						door_d  = 1'b1;
						motor_d = MOTOR_STOP;
						pulse_d = 1'b1;
						mode_d  = MODE_WAIT;
					end
				end
				MODE_DOWN: begin
					door_d  = 1'b0;
					dir_d   = DIR_DOWN;
					motor_d = MOTOR_DOWN;
					if (stat.at_bottom) begin
						door_d  = 1'b1;
						motor_d = MOTOR_STOP;
						pulse_d = 1'b1;
						mode_d  = MODE_WAIT;
					end
				end
				default: begin
					// door timeout: keep heading if work lies ahead, else go by highest call
					if (expired) begin
						door_d = 1'b0;
						if (dir_q == DIR_UP && stat.ahead_up) begin
							mode_d = MODE_UP;
						end else if (dir_q == DIR_DOWN && stat.ahead_down) begin
							mode_d = MODE_DOWN;
						end else if (stat.any_pending) begin
							mode_d = stat.at_or_above ? MODE_UP : MODE_DOWN;
						end
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/elevator_request_controller_top.sv =====
`timescale 1ns / 1ps
// Elevator request controller.
// req channel: one control tick per request (floor sensor, hall up/down and cab
// presses, door timer expiry). rsp channel: one result per request with motor
// command, door state, floor indicator, pending request lamps, a timer start
// pulse and the current mode.
// A request accepted at a clock edge is registered in the input register; the
// state and result register update once the result slot is free, and the result is then offered.
// Throughput: one request per cycle while rsp is taken; the limit is the single
// state update between the input register and the state/result register.
// Reset puts the block in init mode (motor up until a floor is sensed, door
// closed, no requests, direction up) and empties both registers.
// When the receiver stalls, the result and the state hold, one more request
// is held in the input register, and req.ready then drops until rsp moves.
`include "assert_macros.svh"

module elevator_request_controller_top #(
	parameter int FLOORS = elv_pkg::FLOORS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	elv_req_if.sink   req,
	elv_rsp_if.source rsp
);
	import elv_pkg::*;

	localparam int FLOOR_W = $clog2(FLOORS);

	// input register
	logic               valid_s1;
	logic               sv_s1;
	logic [FLOOR_W-1:0] fl_s1;
	logic [FLOORS-1:0]  upp_s1;
	logic [FLOORS-1:0]  dnp_s1;
	logic [FLOORS-1:0]  cbp_s1;
	logic               exp_s1;

	// state, which doubles as the result register
	mode_t              mode_q;
	logic               dir_q;
	logic [FLOOR_W-1:0] floor_q;
	logic               door_q;
	motor_t             motor_q;
	logic [FLOORS-1:0]  up_q;
	logic [FLOORS-1:0]  dn_q;
	logic [FLOORS-1:0]  cab_q;
	logic               pulse_q;
	logic               out_valid_q;

	// next state
	mode_t              mode_d;
	logic               dir_d;
	logic [FLOOR_W-1:0] floor_d;
	logic               door_d;
	motor_t             motor_d;
	logic [FLOORS-1:0]  up_d;
	logic [FLOORS-1:0]  dn_d;
	logic [FLOORS-1:0]  cab_d;
	logic               pulse_d;
	reqs_stat_t         stat;

	logic advance;

	// handshake: a stored request moves on when the result slot is free
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// input register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	// input register payload
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			sv_s1  <= req.sensor_valid;
			fl_s1  <= req.sensor_floor;
			upp_s1 <= req.up_presses;
			dnp_s1 <= req.down_presses;
			cbp_s1 <= req.cab_presses;
			exp_s1 <= req.timer_expired;
		end
	end

	// request latching and floor scans
	elv_reqs #(
		.FLOORS (FLOORS)
	) u_reqs (
		.hold         (mode_q == MODE_INIT),
		.sensor_valid (sv_s1),
		.sensor_floor (fl_s1),
		.up_presses   (upp_s1),
		.down_presses (dnp_s1),
		.cab_presses  (cbp_s1),
		.floor_q      (floor_q),
		.door_q       (door_q),
		.up_q         (up_q),
		.dn_q         (dn_q),
		.cab_q        (cab_q),
		.floor_d      (floor_d),
		.up_d         (up_d),
		.dn_d         (dn_d),
		.cab_d        (cab_d),
		.stat         (stat)
	);

	// mode, door and motor control
	elv_ctrl u_ctrl (
		.mode_q  (mode_q),
		.dir_q   (dir_q),
		.door_q  (door_q),
		.motor_q (motor_q),
		.expired (exp_s1),
		.stat    (stat),
		.mode_d  (mode_d),
		.dir_d   (dir_d),
		.door_d  (door_d),
		.motor_d (motor_d),
		.pulse_d (pulse_d)
	);

	// state and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_INIT;
			dir_q       <= DIR_UP;
			floor_q     <= '0;
			door_q      <= 1'b0;
			motor_q     <= MOTOR_STOP;
			up_q        <= '0;
			dn_q        <= '0;
			cab_q       <= '0;
			pulse_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				mode_q  <= mode_d;
				dir_q   <= dir_d;
				floor_q <= floor_d;
				door_q  <= door_d;
				motor_q <= motor_d;
				up_q    <= up_d;
				dn_q    <= dn_d;
				cab_q   <= cab_d;
				pulse_q <= pulse_d;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result outputs
	assign rsp.valid        = out_valid_q;
	assign rsp.motor_drive  = motor_q;
	assign rsp.door_is_open = door_q;
	assign rsp.floor_shown  = floor_q;
	assign rsp.up_lamps     = up_q;
	assign rsp.down_lamps   = dn_q;
	assign rsp.cab_lamps    = cab_q;
	assign rsp.timer_start  = pulse_q;
	assign rsp.mode_now     = mode_q;

	// checks; a stop can be followed by a timeout in the same tick, so the
	// door may already be closed and a new direction chosen when the pulse shows
	`ASSERT_CLK(a_pulse_opens, clk, arst_n,
		pulse_q |-> (motor_q == MOTOR_STOP && mode_q != MODE_INIT),
		"timer start without a stop")
	`ASSERT_NEVER(a_move_door_open, clk, arst_n,
		door_q && (motor_q != MOTOR_STOP || mode_q == MODE_UP || mode_q == MODE_DOWN),
		"door open while moving")
	`ASSERT_NEVER(a_end_calls, clk, arst_n,
		dn_q[0] || up_q[FLOORS-1],
		"call latched beyond an end floor")
	`ASSERT_CLK(a_stall_holds, clk, arst_n,
		(out_valid_q && !rsp.ready) |=> ($stable(mode_q) && $stable(cab_q) && $stable(floor_q)),
		"state moved under a stalled result")

endmodule
